### hw/rtl/first_fit_heap_allocator_defines.svh
// assertion macros used by the allocator's rtl
// no dependencies; included by first_fit_heap_allocator.sv
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// next-cycle implication, off while reset is asserted
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

### hw/rtl/ffha_pkg.sv
// shared types and codes for the first-fit heap allocator
// no dependencies; imported by ffha_hdr_ram and first_fit_heap_allocator
package ffha_pkg;

    // fixed field widths of the stream words
    localparam int OP_W        = 2;
    localparam int REQ_W       = 11;
    localparam int BADDR_W     = 10;
    localparam int OUT_ADDR_W  = 10;
    localparam int CFG_W       = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_NO_FIT = 1'b1;

    localparam logic [CFG_W-1:0] HEAP_SIZE_RESET = 11'd1024;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_LOOK,
        ST_WALK,
        ST_WR_REM,
        ST_WR_CUR,
        ST_WR_PREV,
        ST_FREE,
        ST_INIT,
        ST_RESP
    } ffha_state_t;

endpackage

### hw/rtl/ffha_hdr_ram.sv
// block header memory: one write port, one read port, registered read data
// uses ffha_pkg
module ffha_hdr_ram
    import ffha_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 22
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator. Each input word (alloc, free, init or another op) yields one
// result word. Headers (size, next-free link) live in one memory indexed by byte offset,
// read one per cycle. An alloc reads free-list headers, at most HEAP_BYTES/HEADER_BYTES + 1
// (i.e. 129 at the defaults); on a fit it writes the split remainder if any, the chosen
// header and the previous header if there is one. An in-range free or an init writes one
// header. After reset the block writes the heap's first header before it takes
// a word. A finished result waits in an output register while the next word is accepted.
// depends on ffha_pkg, ffha_hdr_ram and first_fit_heap_allocator_defines.svh
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 1024,
    parameter int ALIGN_BYTES  = 4,
    parameter int HEADER_BYTES = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,        // heap_size
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,    // req_size [10:0], block_addr [20:11]
    input  logic [OP_W-1:0]        s_axis_tuser,    // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,    // out_addr [9:0]
    output logic [0:0]             m_axis_tuser     // status
);

    localparam int AW   = $clog2(HEAP_BYTES);
    localparam int SW   = $clog2(HEAP_BYTES + 1);
    localparam int DW   = 2 * SW;
    localparam int CW   = ((SW > REQ_W) ? SW : REQ_W) + 2;
    localparam int VW   = REQ_W + 1;
    localparam int SH   = VW + 4;
    localparam int RW   = SH + 1;
    localparam int PW   = VW + RW;
    localparam int WALK_LIMIT = HEAP_BYTES / HEADER_BYTES + 1;
    localparam int STW  = $clog2(WALK_LIMIT + 1);

    localparam logic [RW-1:0]  RECIP      = RW'((2 ** SH + ALIGN_BYTES - 1) / ALIGN_BYTES);
    localparam logic [SW-1:0]  LIST_END   = SW'(HEAP_BYTES);
    localparam logic [CW-1:0]  HEAP_C     = CW'(HEAP_BYTES);
    localparam logic [CW-1:0]  HDR_C      = CW'(HEADER_BYTES);
    localparam logic [CW-1:0]  SPLIT_MIN  = CW'(HEADER_BYTES + ALIGN_BYTES);
    localparam logic [CW-1:0]  FREE_SAT   = CW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [VW-1:0]  ROUND_ADD  = VW'(ALIGN_BYTES - 1);
    localparam logic [STW-1:0] STEP_LIMIT = STW'(WALK_LIMIT);

    ffha_state_t state_reg, state_next;

    // control registers
    logic [SW-1:0]    head_reg, head_next;
    logic [CFG_W-1:0] heap_size_reg;
    logic             out_valid_reg;
    logic [OUT_ADDR_W-1:0] out_addr_reg;
    logic             out_status_reg;

    // per-word working registers
    logic [REQ_W-1:0] req_reg, req_next;
    logic [AW-1:0]    blk_reg, blk_next;
    logic [VW-1:0]    q_reg, q_next;
    logic [CW-1:0]    m_reg, m_next;
    logic [CW-1:0]    need_reg, need_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [AW-1:0]    prev_reg, prev_next;
    logic [SW-1:0]    prev_size_reg, prev_size_next;
    logic             prev_valid_reg, prev_valid_next;
    logic [STW-1:0]   steps_reg, steps_next;
    logic [SW-1:0]    sz_reg, sz_next;
    logic [SW-1:0]    succ_reg, succ_next;
    logic             split_reg, split_next;
    logic [AW-1:0]    rem_reg, rem_next;
    logic [AW-1:0]    res_addr_reg, res_addr_next;
    logic             res_fail_reg, res_fail_next;

    // memory port
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    logic          in_accept;
    logic          out_load;

    logic [REQ_W-1:0]   in_req;
    logic [BADDR_W-1:0] in_baddr;

    logic [SW-1:0] rd_size;
    logic [SW-1:0] rd_next;
    logic [CW-1:0] rd_size_c;
    logic          hdr_fits;
    logic          split_ok;
    logic          next_is_end;
    logic          blk_in_range;
    logic [VW-1:0] round_v;
    logic [PW-1:0] round_prod;
    logic [SW-1:0] cur_new_size;
    logic [SW-1:0] rem_size;
    logic [SW-1:0] new_succ;
    logic [SW-1:0] prev_fwd_size;
    logic [SW-1:0] free_size;
    logic [SW-1:0] init_size;

    assign in_req   = s_axis_tdata[REQ_W-1:0];
    assign in_baddr = s_axis_tdata[REQ_W +: BADDR_W];

    assign rd_size   = rd_data[DW-1:SW];
    assign rd_next   = rd_data[SW-1:0];
    assign rd_size_c = CW'(rd_size);

    assign hdr_fits     = rd_size_c >= need_reg;
    assign split_ok     = ((rd_size_c - need_reg) >= SPLIT_MIN) &&
                          ((CW'(cur_reg) + need_reg) < HEAP_C);
    assign next_is_end  = CW'(rd_next) >= HEAP_C;
    assign blk_in_range = CW'(in_baddr) < HEAP_C;

    // round up to the alignment: ceil reciprocal is exact over the request range
    assign round_v    = VW'(req_reg) + ROUND_ADD;
    assign round_prod = PW'(round_v) * PW'(RECIP);

    assign cur_new_size  = split_reg ? SW'(m_reg) : SW'(CW'(sz_reg) - HDR_C);
    assign rem_size      = SW'(CW'(sz_reg) - need_reg);
    assign new_succ      = split_reg ? SW'(rem_reg) : succ_reg;
    // prev may alias an entry rewritten just before it in a looped list
    assign prev_fwd_size = (prev_reg == cur_reg) ? cur_new_size :
                           (split_reg && (prev_reg == rem_reg)) ? rem_size :
                           prev_size_reg;
    assign free_size     = (rd_size_c > FREE_SAT) ? LIST_END : SW'(rd_size_c + HDR_C);
    assign init_size     = (CW'(heap_size_reg) > HEAP_C) ? LIST_END : SW'(heap_size_reg);

    assign in_accept = s_axis_tvalid && s_axis_tready;

    ffha_hdr_ram #(
        .DEPTH (HEAP_BYTES),
        .AW    (AW),
        .DW    (DW)
    ) u_hdr_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (s_axis_tuser)
                        OP_ALLOC: state_next = ST_SCALE;
                        OP_FREE:  state_next = blk_in_range ? ST_FREE : ST_RESP;
                        OP_INIT:  state_next = ST_INIT;
                        default:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCALE:
            begin
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                state_next = (CW'(head_reg) >= HEAP_C) ? ST_RESP : ST_WALK;
            end
            ST_WALK:
            begin
                if (hdr_fits)
                begin
                    state_next = split_ok ? ST_WR_REM : ST_WR_CUR;
                end
                else if (next_is_end || (steps_reg >= STEP_LIMIT))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_WR_REM:
            begin
                state_next = ST_WR_CUR;
            end
            ST_WR_CUR:
            begin
                state_next = prev_valid_reg ? ST_WR_PREV : ST_RESP;
            end
            ST_WR_PREV, ST_FREE, ST_INIT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: handshake and memory port
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = AW'(in_baddr);
        wr_en         = 1'b0;
        wr_addr       = cur_reg;
        wr_data       = {cur_new_size, succ_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {LIST_END, LIST_END};
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                rd_en         = s_axis_tvalid && (s_axis_tuser == OP_FREE);
                rd_addr       = AW'(in_baddr);
            end
            ST_LOOK:
            begin
                rd_en   = CW'(head_reg) < HEAP_C;
                rd_addr = AW'(head_reg);
            end
            ST_WALK:
            begin
                rd_en   = !hdr_fits && !next_is_end && (steps_reg < STEP_LIMIT);
                rd_addr = AW'(rd_next);
            end
            ST_WR_REM:
            begin
                wr_en   = 1'b1;
                wr_addr = rem_reg;
                wr_data = {rem_size, succ_reg};
            end
            ST_WR_CUR:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = {cur_new_size, succ_reg};
            end
            ST_WR_PREV:
            begin
                wr_en   = 1'b1;
                wr_addr = prev_reg;
                wr_data = {prev_fwd_size, new_succ};
            end
            ST_FREE:
            begin
                wr_en   = 1'b1;
                wr_addr = blk_reg;
                wr_data = {free_size, head_reg};
            end
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {init_size, LIST_END};
            end
            ST_RESP:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // working register updates
    always_comb
    begin
        head_next       = head_reg;
        req_next        = req_reg;
        blk_next        = blk_reg;
        q_next          = q_reg;
        m_next          = m_reg;
        need_next       = need_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_size_next  = prev_size_reg;
        prev_valid_next = prev_valid_reg;
        steps_next      = steps_reg;
        sz_next         = sz_reg;
        succ_next       = succ_reg;
        split_next      = split_reg;
        rem_next        = rem_reg;
        res_addr_next   = res_addr_reg;
        res_fail_next   = res_fail_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                head_next = '0;
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_next      = in_req;
                    blk_next      = AW'(in_baddr);
                    res_addr_next = '0;
                    res_fail_next = STATUS_DONE;
                end
            end
            ST_SCALE:
            begin
                q_next = round_prod[SH +: VW];
            end
            ST_LOOK:
            begin
                m_next          = CW'(q_reg) * CW'(ALIGN_BYTES);
                need_next       = CW'(q_reg) * CW'(ALIGN_BYTES) + HDR_C;
                cur_next        = AW'(head_reg);
                prev_valid_next = 1'b0;
                steps_next      = STW'(1);
                if (CW'(head_reg) >= HEAP_C)
                begin
                    res_fail_next = STATUS_NO_FIT;
                end
            end
            ST_WALK:
            begin
                if (hdr_fits)
                begin
                    sz_next    = rd_size;
                    succ_next  = rd_next;
                    split_next = split_ok;
                    rem_next   = AW'(CW'(cur_reg) + need_reg);
                end
                else if (next_is_end || (steps_reg >= STEP_LIMIT))
                begin
                    res_fail_next = STATUS_NO_FIT;
                end
                else
                begin
                    prev_next       = cur_reg;
                    prev_size_next  = rd_size;
                    prev_valid_next = 1'b1;
                    cur_next        = AW'(rd_next);
                    steps_next      = steps_reg + STW'(1);
                end
            end
            ST_WR_CUR:
            begin
                res_addr_next = cur_reg;
                if (!prev_valid_reg)
                begin
                    head_next = new_succ;
                end
            end
            ST_FREE:
            begin
                head_next = SW'(blk_reg);
            end
            ST_INIT:
            begin
                head_next = '0;
            end
            default:
            begin
                res_fail_next = res_fail_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            head_reg      <= '0;
            heap_size_reg <= HEAP_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            if (cfg_valid && cfg_ready)
            begin
                heap_size_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        blk_reg        <= blk_next;
        q_reg          <= q_next;
        m_reg          <= m_next;
        need_reg       <= need_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_size_reg  <= prev_size_next;
        prev_valid_reg <= prev_valid_next;
        steps_reg      <= steps_next;
        sz_reg         <= sz_next;
        succ_reg       <= succ_next;
        split_reg      <= split_next;
        rem_reg        <= rem_next;
        res_addr_reg   <= res_addr_next;
        res_fail_reg   <= res_fail_next;
        if (out_load)
        begin
            out_addr_reg   <= OUT_ADDR_W'(res_addr_reg);
            out_status_reg <= res_fail_reg;
        end
    end

    assign cfg_ready       = 1'b1;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = OUT_TDATA_W'(out_addr_reg);
    assign m_axis_tuser[0] = out_status_reg;

    `FFHA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_accept, state_reg != ST_IDLE)
    `FFHA_ASSERT_NOW(a_head_in_range, clk, rst_n, 1'b1, CW'(head_reg) <= HEAP_C)
    `FFHA_ASSERT_NOW(a_walk_steps, clk, rst_n, state_reg == ST_WALK, (steps_reg != '0) && (steps_reg <= STEP_LIMIT))
    `FFHA_ASSERT_NOW(a_fail_addr_zero, clk, rst_n, out_valid_reg && (out_status_reg == STATUS_NO_FIT), out_addr_reg == '0)

endmodule
